// ===== rtl/upd_pkg.sv =====
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = 2;
	localparam int unsigned CNT_W      = 3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} upd_phase_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
	} upd_entry_t;

	typedef struct packed {
		logic [1:0] count;
		upd_entry_t first;
		upd_entry_t second;
	} upd_res_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				v = c - 8'h30;
			end else if (c >= 8'h61 && c <= 8'h66) begin
				v = c - 8'h57;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				v = c - 8'h37;
			end
			return v[3:0];
		end
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

// ===== rtl/upd_decode.sv =====
module upd_decode
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output upd_res_t   res
);

	upd_phase_t phase_q, phase_d;
	logic [7:0] held_q, held_d;

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		held_d  = held_q;
		unique case (phase_q)
			PH_PCT: begin
				if (last_in) begin
					res.count           = 2'd2;
					res.first.byte_val  = CH_PERCENT;
					res.first.last      = 1'b0;
					res.second.byte_val = plain_byte(byte_in);
					res.second.last     = 1'b1;
					phase_d             = PH_IDLE;
					held_d              = 8'd0;
				end else begin
					held_d  = byte_in;
					phase_d = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				res.count          = 2'd1;
				res.first.byte_val = {hex_value(held_q), hex_value(byte_in)};
				res.first.last     = last_in;
				phase_d            = PH_IDLE;
				held_d             = 8'd0;
			end
			default: begin
				phase_d = PH_IDLE;
				if (byte_in == CH_PERCENT && !last_in) begin
					phase_d = PH_PCT;
				end else begin
					res.count          = 2'd1;
					res.first.byte_val = plain_byte(byte_in);
					res.first.last     = last_in;
				end
			end
		endcase
		if (!advance) begin
			res.count = 2'd0;
			phase_d   = phase_q;
			held_d    = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// ===== rtl/upd_result_fifo.sv =====
module upd_result_fifo
	import upd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  upd_res_t         push,
	output logic             room,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic             out_valid,
	input  logic             out_ready
);

	upd_entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pop;
	logic [PTR_W-1:0]       wr_ptr_next;

	assign out_valid   = (count_q != '0);
	assign pop         = out_valid && out_ready;
	assign room        = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign wr_ptr_next = wr_ptr_q + PTR_W'(1);
	assign out_byte    = mem_q[rd_ptr_q].byte_val;
	assign out_last    = mem_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q <= CNT_W'(FIFO_DEPTH - 2))
		else $error("push without room");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd0 && !pop) |=> $stable(count_q))
		else $error("count changed without push or pop");

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Each input is registered, then decoded into the result queue that drives out_valid.
// One input item per cycle while the queue has room; one result item leaves per cycle
// while out_ready is high, so the '%' and last byte of a cut escape leave in turn.
// A four-entry result queue parts the input side from the output side.
// Reset (arst_n low) empties the input register and the queue and clears the escape state.
module url_percent_decoder
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       advance;
	upd_res_t   res;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	upd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	upd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.room      (room),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// ===== tb/url_percent_decoder_checker.sv =====
module url_percent_decoder_checker
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	input  logic       out_valid,
	input  logic       out_ready,
	output int         mismatches,
	output int         outstanding
);

	upd_phase_t phase;
	logic [7:0] held_byte;
	upd_entry_t decoded_q[$];

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]})
			v = c[3:0];
		else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
			v = c[3:0] + 4'd9;
		return v;
	endfunction

	function automatic logic [7:0] unplus(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic l);
		case (phase)
			PH_PCT: begin
				if (l) begin
					decoded_q.push_back('{byte_val: CH_PERCENT, last: 1'b0});
					decoded_q.push_back('{byte_val: unplus(b), last: 1'b1});
					phase = PH_IDLE;
					held_byte = '0;
				end else begin
					held_byte = b;
					phase = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				decoded_q.push_back('{byte_val: {digit_value(held_byte), digit_value(b)},
					last: l});
				phase = PH_IDLE;
				held_byte = '0;
			end
			default: begin
				if (b == CH_PERCENT && !l) begin
					phase = PH_PCT;
				end else begin
					decoded_q.push_back('{byte_val: unplus(b), last: l});
					phase = PH_IDLE;
				end
			end
		endcase
	endtask

	task automatic check_result(input logic [7:0] b, input logic l);
		upd_entry_t want;
		if (decoded_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected item: out_byte %h out_last %b", b, l);
		end else begin
			want = decoded_q.pop_front();
			if (want.byte_val !== b || want.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte %h last %b, got byte %h last %b",
						want.byte_val, want.last, b, l);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			held_byte = '0;
			decoded_q.delete();
		end else begin
			if (in_valid && in_ready)
				decode_byte(in_byte, in_last);
			if (out_valid && out_ready)
				check_result(out_byte, out_last);
		end
		outstanding = decoded_q.size();
	end

endmodule

// ===== tb/url_percent_decoder_tb.sv =====
module url_percent_decoder_tb;
	import upd_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 40;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic [7:0] in_byte   = '0;
	logic       in_last   = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_valid;
	logic       out_ready = 1'b0;

	int         mismatches;
	int         outstanding;
	bit         noisy = 1'b0;
	bit         calm  = 1'b0;
	int         hold_req = 0;
	int         hold_done = 0;
	int         sent = 0;
	int         cycles = 0;
	logic [7:0] text_q[$];

	url_percent_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_byte (out_byte),
		.out_last (out_last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	url_percent_decoder_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (noisy && !calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		logic took;
		if (noisy && !calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_byte  <= b;
		in_last  <= l;
		in_valid <= 1'b1;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_item(text_q[i], i == text_q.size() - 1);
	endtask

	// hold the sender until every expected item has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] hex_char();
		int n;
		n = $urandom_range(0, 21);
		if (n < 10)
			return 8'h30 + 8'(n);
		else if (n < 16)
			return 8'h61 + 8'(n - 10);
		else
			return 8'h41 + 8'(n - 16);
	endfunction

	task automatic make_text(input int target);
		text_q.delete();
		while (text_q.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					text_q.push_back(CH_PERCENT);
					text_q.push_back(hex_char());
					text_q.push_back(hex_char());
				end
				4: text_q.push_back(CH_PLUS);
				5: begin
					text_q.push_back(CH_PERCENT);
					text_q.push_back(8'($urandom_range(0, 255)));
					text_q.push_back(8'($urandom_range(0, 255)));
				end
				6: text_q.push_back(CH_PERCENT);
				default: text_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		// now and then drop the last one or two bytes, which can cut an escape short
		if ($urandom_range(0, 3) == 0 && text_q.size() > 2)
			repeat ($urandom_range(1, 2)) void'(text_q.pop_back());
	endtask

	initial begin
		int strings;
		int start_count;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(8'h7F, 1'b1);
		send_item(CH_PERCENT, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(CH_PLUS, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(8'h41, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h31, 1'b0);
		send_item(CH_PERCENT, 1'b0);
		send_item(8'h66, 1'b0);
		send_item(8'h46, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(CH_PERCENT, 1'b0);
		send_item(8'h61, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(8'h47, 1'b0);
		send_item(8'h7A, 1'b1);
		send_item(CH_PERCENT, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(CH_PLUS, 1'b1);
		drain();

		strings = 0;
		start_count = sent;
		while (sent - start_count < RANDOM_ITEMS) begin
			strings++;
			calm <= (sent - start_count > RANDOM_ITEMS - 120);
			if (strings == 10 || strings == 60) begin
				noisy <= 1'b0;
				hold_req <= hold_req + 1;
				make_text(24);
			end else begin
				noisy <= ($urandom_range(0, 2) != 0);
				make_text(($urandom_range(0, 9) == 0) ? $urandom_range(15, 30)
					: $urandom_range(1, 10));
			end
			send_text();
			if (strings % 25 == 0)
				drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
